/* src/swv_pkg.sv */
// Package for the sliding-window variance block: widths, microcode format and program.
`timescale 1ns / 1ps

package swv_pkg;

  // Field widths and register reset values.
  localparam int unsigned MAX_WINDOW_DEF = 16;
  localparam int unsigned WL_W           = 5;
  localparam logic [WL_W-1:0] WL_RESET   = 5'd16;
  localparam int unsigned SMP_W          = 16;
  localparam int unsigned VAR_W          = 31;
  localparam logic [VAR_W-1:0] VAR_LIMIT = 31'h4000_0000;

  // Width of a squared deviation: |d| < 2^16, so d*d < 2^32.
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned DIFF_W = SMP_W + 1;

  // Datapath operation selected by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_WR0,
    OP_RD,
    OP_SUM_ACC,
    OP_DIV_START,
    OP_MEAN,
    OP_DIFF,
    OP_MUL,
    OP_SQ_ACC,
    OP_OUT
  } op_e;

  // Jump condition of one control word.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_IDX_ZERO,
    C_IDX_LAST,
    C_DIV_DONE,
    C_OUT_FREE
  } cond_e;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  jmp_t;
    upc_t  jmp_f;
  } ucode_t;

  // Step addresses of the program.
  localparam upc_t U_IDLE      = 4'd0;
  localparam upc_t U_SHIFT_RD  = 4'd1;
  localparam upc_t U_SHIFT_WR  = 4'd2;
  localparam upc_t U_WR0       = 4'd3;
  localparam upc_t U_SUM_RD    = 4'd4;
  localparam upc_t U_SUM_ACC   = 4'd5;
  localparam upc_t U_DIV1      = 4'd6;
  localparam upc_t U_DIV1_WAIT = 4'd7;
  localparam upc_t U_MEAN      = 4'd8;
  localparam upc_t U_SQ_RD     = 4'd9;
  localparam upc_t U_SQ_DIFF   = 4'd10;
  localparam upc_t U_SQ_MUL    = 4'd11;
  localparam upc_t U_SQ_ACC    = 4'd12;
  localparam upc_t U_DIV2      = 4'd13;
  localparam upc_t U_DIV2_WAIT = 4'd14;
  localparam upc_t U_OUT       = 4'd15;

  // Program ROM: one control word per step.
  function automatic ucode_t ucode_rom(upc_t upc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, jmp_t: U_IDLE, jmp_f: U_IDLE};
    case (upc)
      U_IDLE:      w = '{op: OP_ACCEPT,    cond: C_IN_VALID, jmp_t: U_SHIFT_RD,
                         jmp_f: U_IDLE};
      U_SHIFT_RD:  w = '{op: OP_SHIFT_RD,  cond: C_IDX_ZERO, jmp_t: U_WR0,
                         jmp_f: U_SHIFT_WR};
      U_SHIFT_WR:  w = '{op: OP_SHIFT_WR,  cond: C_ALWAYS,   jmp_t: U_SHIFT_RD,
                         jmp_f: U_SHIFT_RD};
      U_WR0:       w = '{op: OP_WR0,       cond: C_ALWAYS,   jmp_t: U_SUM_RD,
                         jmp_f: U_SUM_RD};
      U_SUM_RD:    w = '{op: OP_RD,        cond: C_ALWAYS,   jmp_t: U_SUM_ACC,
                         jmp_f: U_SUM_ACC};
      U_SUM_ACC:   w = '{op: OP_SUM_ACC,   cond: C_IDX_LAST, jmp_t: U_DIV1,
                         jmp_f: U_SUM_RD};
      U_DIV1:      w = '{op: OP_DIV_START, cond: C_ALWAYS,   jmp_t: U_DIV1_WAIT,
                         jmp_f: U_DIV1_WAIT};
      U_DIV1_WAIT: w = '{op: OP_NOP,       cond: C_DIV_DONE, jmp_t: U_MEAN,
                         jmp_f: U_DIV1_WAIT};
      U_MEAN:      w = '{op: OP_MEAN,      cond: C_ALWAYS,   jmp_t: U_SQ_RD,
                         jmp_f: U_SQ_RD};
      U_SQ_RD:     w = '{op: OP_RD,        cond: C_ALWAYS,   jmp_t: U_SQ_DIFF,
                         jmp_f: U_SQ_DIFF};
      U_SQ_DIFF:   w = '{op: OP_DIFF,      cond: C_ALWAYS,   jmp_t: U_SQ_MUL,
                         jmp_f: U_SQ_MUL};
      U_SQ_MUL:    w = '{op: OP_MUL,       cond: C_ALWAYS,   jmp_t: U_SQ_ACC,
                         jmp_f: U_SQ_ACC};
      U_SQ_ACC:    w = '{op: OP_SQ_ACC,    cond: C_IDX_LAST, jmp_t: U_DIV2,
                         jmp_f: U_SQ_RD};
      U_DIV2:      w = '{op: OP_DIV_START, cond: C_ALWAYS,   jmp_t: U_DIV2_WAIT,
                         jmp_f: U_DIV2_WAIT};
      U_DIV2_WAIT: w = '{op: OP_NOP,       cond: C_DIV_DONE, jmp_t: U_OUT,
                         jmp_f: U_DIV2_WAIT};
      U_OUT:       w = '{op: OP_OUT,       cond: C_OUT_FREE, jmp_t: U_IDLE,
                         jmp_f: U_OUT};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,   jmp_t: U_IDLE,
                         jmp_f: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* src/swv_sample_if.sv */
// Input channel interface carrying one signed sample per beat.
`timescale 1ns / 1ps

interface swv_sample_if;
  import swv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* src/swv_variance_if.sv */
// Output channel interface carrying one variance result per beat.
`timescale 1ns / 1ps

interface swv_variance_if;
  import swv_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAR_W-1:0] variance;

  modport source (output valid, output variance, input ready);
  modport sink (input valid, input variance, output ready);
endinterface

/* src/swv_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module swv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/swv_div.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module swv_div #(
  parameter int unsigned DW = 38,
  parameter int unsigned VW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [VW-1:0]    rem_q, rem_d;
  logic [VW-1:0]    dsr_q, dsr_d;
  logic [VW:0]      rem_shift;
  logic [VW:0]      rem_sub;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_shift = {rem_q, quo_q[DW-1]};
  assign rem_sub   = rem_shift - {1'b0, dsr_q};
  assign fits      = rem_shift >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? rem_sub[VW-1:0] : rem_shift[VW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/sliding_window_variance.sv */
// Sliding-window population variance: a microcoded sequencer over a window RAM and a divider.
`timescale 1ns / 1ps

// Each accepted sample is pushed into a window of the last L samples, where L is
// window_length clamped to 1..MAX_WINDOW, and the block returns the population
// variance of that window about its truncated mean, saturated at 2^30. One sample
// is processed at a time by a short microprogram that walks the window RAM three
// times (shift, sum, squared deviations) and runs the shared bit-serial divider
// twice; the divider works on ACCW-bit values, where ACCW is 33 plus the bit count
// of MAX_WINDOW. A new sample is taken while the previous result still waits on the
// output register. The window reads as zero after reset through per-entry valid
// bits, so no clearing pass is needed. window_length may only be written while the
// block is idle.
module sliding_window_variance #(
  parameter int unsigned MAX_WINDOW = swv_pkg::MAX_WINDOW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    window_length_we_i,
  input  logic [swv_pkg::WL_W-1:0] window_length_i,
  swv_sample_if.sink              smp_i,
  swv_variance_if.source          var_o
);
  import swv_pkg::*;

  localparam int unsigned LW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AW   = $clog2(MAX_WINDOW);
  localparam int unsigned CW   = (LW > WL_W) ? LW : WL_W;
  localparam int unsigned ACCW = SQ_W + 1 + LW;

  // Configuration register.
  logic [WL_W-1:0] window_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WL_RESET;
    end else if (window_length_we_i) begin
      window_length_q <= window_length_i;
    end
  end

  // Effective window length: zero acts as one, large values clamp to the store.
  logic [CW-1:0] wl_ext;
  logic [LW-1:0] eff_len;

  assign wl_ext = CW'(window_length_q);

  always_comb begin
    if (wl_ext == '0) begin
      eff_len = LW'(1);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = LW'(wl_ext);
    end
  end

  // Sequencer and datapath registers.
  upc_t                     upc_q, upc_d;
  ucode_t                   uw;
  logic                     taken;
  logic [LW-1:0]            len_q;
  logic [AW-1:0]            idx_q;
  logic signed [SMP_W-1:0]  sample_q;
  logic signed [ACCW-1:0]   acc_q;
  logic                     neg_q;
  logic signed [SMP_W-1:0]  mean_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [SQ_W-1:0]          sq_q;
  logic [MAX_WINDOW-1:0]    valid_q;
  logic                     rd_vld_q;
  logic                     out_valid_q;
  logic [VAR_W-1:0]         result_q;

  // Datapath wiring.
  logic                     idx_zero;
  logic                     idx_last;
  logic                     out_free;
  logic                     in_beat;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [SMP_W-1:0]         ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [SMP_W-1:0]         ram_rdata;
  logic signed [SMP_W-1:0]  rd_data;
  logic [ACCW-1:0]          acc_mag;
  logic                     div_start;
  logic                     div_done;
  logic [ACCW-1:0]          div_quo;
  logic [DIFF_W:0]          mean_ext;
  logic signed [2*DIFF_W-1:0] prod;

  assign uw       = ucode_rom(upc_q);
  assign idx_zero = (idx_q == '0);
  assign idx_last = (LW'(idx_q) == len_q - LW'(1));
  assign out_free = !out_valid_q || var_o.ready;
  assign in_beat  = smp_i.valid && smp_i.ready;

  // Jump condition of the current step.
  always_comb begin
    case (uw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_IN_VALID: taken = smp_i.valid;
      C_IDX_ZERO: taken = idx_zero;
      C_IDX_LAST: taken = idx_last;
      C_DIV_DONE: taken = div_done;
      C_OUT_FREE: taken = out_free;
      default:    taken = 1'b1;
    endcase
  end

  assign upc_d = taken ? uw.jmp_t : uw.jmp_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Window RAM ports, driven by the current operation.
  assign ram_we    = (uw.op == OP_SHIFT_WR) || (uw.op == OP_WR0);
  assign ram_waddr = (uw.op == OP_WR0) ? '0 : idx_q;
  assign ram_wdata = (uw.op == OP_WR0) ? sample_q : rd_data;
  assign ram_re    = ((uw.op == OP_SHIFT_RD) && !idx_zero) || (uw.op == OP_RD);
  assign ram_raddr = (uw.op == OP_SHIFT_RD) ? idx_q - AW'(1) : idx_q;

  swv_ram #(
    .WIDTH (SMP_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= valid_q[ram_raddr];
      end
    end
  end

  assign rd_data = rd_vld_q ? $signed(ram_rdata) : '0;

  // Shared divider for the mean and the variance.
  assign acc_mag   = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
  assign div_start = (uw.op == OP_DIV_START);

  swv_div #(
    .DW (ACCW),
    .VW (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_mag),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Truncated mean: restore the sign of the quotient magnitude.
  assign mean_ext = neg_q ? -{2'b00, div_quo[SMP_W-1:0]} : {2'b00, div_quo[SMP_W-1:0]};
  assign prod     = (2*DIFF_W)'(diff_q) * (2*DIFF_W)'(diff_q);

  // Datapath registers, updated by the operation of the current step.
  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_ACCEPT: begin
        if (in_beat) begin
          sample_q <= smp_i.sample;
          len_q    <= eff_len;
          idx_q    <= AW'(eff_len - LW'(1));
        end
      end
      OP_SHIFT_WR: begin
        idx_q <= idx_q - AW'(1);
      end
      OP_WR0: begin
        idx_q <= '0;
        acc_q <= '0;
      end
      OP_SUM_ACC: begin
        acc_q <= acc_q + ACCW'(rd_data);
        idx_q <= idx_q + AW'(1);
      end
      OP_DIV_START: begin
        neg_q <= acc_q[ACCW-1];
      end
      OP_MEAN: begin
        mean_q <= $signed(mean_ext[SMP_W-1:0]);
        acc_q  <= '0;
        idx_q  <= '0;
      end
      OP_DIFF: begin
        diff_q <= DIFF_W'(rd_data) - DIFF_W'(mean_q);
      end
      OP_MUL: begin
        sq_q <= prod[SQ_W-1:0];
      end
      OP_SQ_ACC: begin
        acc_q <= acc_q + $signed({{(ACCW-SQ_W){1'b0}}, sq_q});
        idx_q <= idx_q + AW'(1);
      end
      OP_OUT: begin
        if (out_free) begin
          result_q <= (div_quo > ACCW'(VAR_LIMIT)) ? VAR_LIMIT : div_quo[VAR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished result until its beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !var_o.ready) || ((uw.op == OP_OUT) && out_free);
    end
  end

  assign smp_i.ready    = (uw.op == OP_ACCEPT);
  assign var_o.valid    = out_valid_q;
  assign var_o.variance = result_q;

endmodule

/* src/swv_checker.sv */
// Port-level checker for the sliding-window variance block, bound to the top level.
`timescale 1ns / 1ps

module swv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [swv_pkg::VAR_W-1:0] variance_i
);
  import swv_pkg::*;

  // A stalled result beat stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(variance_i))
    else $error("result beat dropped or changed while stalled");

  // Results never exceed the saturation bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> variance_i <= VAR_LIMIT)
    else $error("variance above saturation bound");

  // Samples are processed one at a time: no input beat right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a sample is in progress");

  // A new result never rises straight after a step in which input could be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result produced while the input side was open");

endmodule

bind sliding_window_variance swv_checker u_swv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .out_valid_i (var_o.valid),
  .out_ready_i (var_o.ready),
  .variance_i  (var_o.variance)
);
